// ===== rtl/core/vtce_pkg.sv =====
// Shared types, operation codes and flag positions of the VIA timer and control-edge core.
package vtce_pkg;

    localparam int unsigned CountWidth = 16;
    localparam int unsigned FlagWidth  = 7;
    localparam int unsigned CfgIdxWidth  = 2;
    localparam int unsigned CfgDataWidth = 16;

    // Flag bit positions in the interrupt flag word.
    localparam int unsigned FlagCa2 = 0;
    localparam int unsigned FlagCa1 = 1;
    localparam int unsigned FlagCb2 = 3;
    localparam int unsigned FlagCb1 = 4;
    localparam int unsigned FlagT2  = 5;
    localparam int unsigned FlagT1  = 6;

    // Peripheral control bit positions.
    localparam int unsigned PcrCa1Active = 0;
    localparam int unsigned PcrCa2Active = 2;
    localparam int unsigned PcrCa2Output = 3;
    localparam int unsigned PcrCb1Active = 4;
    localparam int unsigned PcrCb2Active = 6;
    localparam int unsigned PcrCb2Output = 7;

    // Auxiliary control bit that makes timer 1 free-running.
    localparam int unsigned AcrT1FreeRun = 6;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_LINE  = 2'd1,
        OP_LOAD  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_PCR     = 2'd0,
        REG_ACR     = 2'd1,
        REG_IER     = 2'd2,
        REG_T1LATCH = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        op_t                   op;
        logic                  port_b;
        logic                  second_line;
        logic                  line_level;
        logic                  timer_select;
        logic [CountWidth-1:0] load_value;
        logic [FlagWidth-1:0]  clear_mask;
    } item_t;

    typedef struct packed {
        logic [7:0]            pcr;
        logic [7:0]            acr;
        logic [FlagWidth-1:0]  ier;
        logic [CountWidth-1:0] t1_latch;
    } cfg_t;

    typedef struct packed {
        logic [CountWidth-1:0] timer2_count;
        logic [CountWidth-1:0] timer1_count;
        logic [FlagWidth-1:0]  flags;
        logic                  irq_active;
    } result_t;

endpackage

// ===== rtl/core/vtce_engine.sv =====
// Timer, control-line and interrupt flag state with its per-word update logic.
module vtce_engine (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,
    input  vtce_pkg::item_t item,
    input  vtce_pkg::cfg_t  cfg,
    output vtce_pkg::result_t result
);

    logic [vtce_pkg::CountWidth-1:0] cnt_reg     [2];
    logic [vtce_pkg::CountWidth-1:0] cnt_next    [2];
    logic [vtce_pkg::CountWidth-1:0] prev_reg    [2];
    logic [vtce_pkg::CountWidth-1:0] prev_next   [2];
    logic [vtce_pkg::CountWidth-1:0] pend_val_reg  [2];
    logic [vtce_pkg::CountWidth-1:0] pend_val_next [2];
    logic [1:0] pend_valid_reg, pend_valid_next;
    logic [1:0] running_reg, running_next;
    logic       reload_reg, reload_next;
    logic       phase2_reg, phase2_next;
    logic [3:0] levels_reg, levels_next;
    logic [vtce_pkg::FlagWidth-1:0] flags_reg, flags_next;

    logic [1:0] slot;
    logic       prev_level;
    logic       line_active;
    logic       line_output;
    logic       edge_hit;

    assign slot = {item.port_b, item.second_line};
    assign prev_level = levels_reg[slot];

    // Line one has no output mode; line two is ignored when driven as output.
    always_comb begin
        unique case (slot)
            2'b00: begin
                line_active = cfg.pcr[vtce_pkg::PcrCa1Active];
                line_output = 1'b0;
            end
            2'b01: begin
                line_active = cfg.pcr[vtce_pkg::PcrCa2Active];
                line_output = cfg.pcr[vtce_pkg::PcrCa2Output];
            end
            2'b10: begin
                line_active = cfg.pcr[vtce_pkg::PcrCb1Active];
                line_output = 1'b0;
            end
            default: begin
                line_active = cfg.pcr[vtce_pkg::PcrCb2Active];
                line_output = cfg.pcr[vtce_pkg::PcrCb2Output];
            end
        endcase
    end

    assign edge_hit = (item.line_level != prev_level) && !line_output
                      && (item.line_level == line_active);

    always_comb begin
        cnt_next        = cnt_reg;
        prev_next       = prev_reg;
        pend_val_next   = pend_val_reg;
        pend_valid_next = pend_valid_reg;
        running_next    = running_reg;
        reload_next     = reload_reg;
        phase2_next     = phase2_reg;
        levels_next     = levels_reg;
        flags_next      = flags_reg;

        unique case (item.op)
            vtce_pkg::OP_TICK: begin
                if (phase2_reg) begin
                    prev_next   = cnt_reg;
                    reload_next = 1'b0;
                    cnt_next[0] = reload_reg ? cfg.t1_latch
                                             : cnt_reg[0] - vtce_pkg::CountWidth'(1);
                    cnt_next[1] = cnt_reg[1] - vtce_pkg::CountWidth'(1);
                    for (int t = 0; t < 2; t++) begin
                        if (pend_valid_reg[t]) begin
                            cnt_next[t] = pend_val_reg[t];
                        end
                    end
                    pend_valid_next = 2'b00;
                    phase2_next     = 1'b0;
                end else begin
                    // Underflow: counter wrapped from zero to all ones while running.
                    if (&cnt_reg[1] && prev_reg[1] == '0 && running_reg[1]) begin
                        running_next[1] = 1'b0;
                        flags_next[vtce_pkg::FlagT2] = 1'b1;
                    end
                    if (&cnt_reg[0] && prev_reg[0] == '0 && running_reg[0]) begin
                        flags_next[vtce_pkg::FlagT1] = 1'b1;
                        if (cfg.acr[vtce_pkg::AcrT1FreeRun]) begin
                            reload_next = 1'b1;
                        end else begin
                            running_next[0] = 1'b0;
                        end
                    end
                    phase2_next = 1'b1;
                end
            end
            vtce_pkg::OP_LINE: begin
                levels_next[slot] = item.line_level;
                if (edge_hit) begin
                    unique case (slot)
                        2'b00:   flags_next[vtce_pkg::FlagCa1] = 1'b1;
                        2'b01:   flags_next[vtce_pkg::FlagCa2] = 1'b1;
                        2'b10:   flags_next[vtce_pkg::FlagCb1] = 1'b1;
                        default: flags_next[vtce_pkg::FlagCb2] = 1'b1;
                    endcase
                end
            end
            vtce_pkg::OP_LOAD: begin
                pend_valid_next[item.timer_select] = 1'b1;
                pend_val_next[item.timer_select]   = item.load_value;
                running_next[item.timer_select]    = 1'b1;
                if (item.timer_select) begin
                    flags_next[vtce_pkg::FlagT2] = 1'b0;
                end else begin
                    flags_next[vtce_pkg::FlagT1] = 1'b0;
                end
            end
            default: begin
                flags_next = flags_reg & ~item.clear_mask;
            end
        endcase
    end

    assign result.irq_active   = |(flags_next & cfg.ier);
    assign result.flags        = flags_next;
    assign result.timer1_count = cnt_next[0];
    assign result.timer2_count = cnt_next[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg[0]     <= '0;
            cnt_reg[1]     <= '0;
            prev_reg[0]    <= '0;
            prev_reg[1]    <= '0;
            pend_valid_reg <= '0;
            running_reg    <= '0;
            reload_reg     <= 1'b0;
            phase2_reg     <= 1'b0;
            levels_reg     <= '0;
            flags_reg      <= '0;
        end else if (step_en) begin
            cnt_reg        <= cnt_next;
            prev_reg       <= prev_next;
            pend_valid_reg <= pend_valid_next;
            running_reg    <= running_next;
            reload_reg     <= reload_next;
            phase2_reg     <= phase2_next;
            levels_reg     <= levels_next;
            flags_reg      <= flags_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            pend_val_reg <= pend_val_next;
        end
    end

endmodule

// ===== rtl/core/via_timers_and_control_edges.sv =====
// Top level of the VIA timer and control-edge core: stream ports, registers, pipeline.
//
// Each input word is one operation: a half-cycle tick, a control line change, a timer
// load or a flag clear, and each produces exactly one result word holding the IRQ
// level, the interrupt flags and both timer counts as they stand after the operation.
// The core takes one word per clock cycle while m_tready does not stall it: a word
// sits in the input register while the timer and flag logic works out the new state,
// and the result moves into the output register once it is free or being drained.
// The output register decouples the two sides: a new word is accepted whenever the
// input register is empty, or when it is full and the output register is empty or
// drains in the same cycle. Configuration writes are always accepted (cfg_ready is
// tied high) and must only be issued while the core is idle. Ticks alternate between
// phase 1 (underflow check) and phase 2 (decrement, latch reload and pending loads);
// the first tick after reset is phase 1.
module via_timers_and_control_edges (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // Bits from 0: port_b, second_line, line_level, timer_select, load_value[15:0],
    // clear_mask[6:0], five unused bits.
    input  logic [31:0] s_tdata,
    // Bits from 0: operation[1:0].
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // Bits from 0: irq_active, flags[6:0], timer1_count[15:0], timer2_count[15:0].
    output logic [39:0] m_tdata,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [vtce_pkg::CfgIdxWidth-1:0]  cfg_index,
    input  logic [vtce_pkg::CfgDataWidth-1:0] cfg_data
);

    logic              in_valid_reg;
    vtce_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    vtce_pkg::result_t out_result_reg;
    vtce_pkg::result_t step_result;
    vtce_pkg::cfg_t    cfg_reg;
    vtce_pkg::item_t   s_item;
    logic              advance;

    // Unpack the incoming word into the item fields.
    assign s_item.op           = vtce_pkg::op_t'(s_tuser);
    assign s_item.port_b       = s_tdata[0];
    assign s_item.second_line  = s_tdata[1];
    assign s_item.line_level   = s_tdata[2];
    assign s_item.timer_select = s_tdata[3];
    assign s_item.load_value   = s_tdata[19:4];
    assign s_item.clear_mask   = s_tdata[26:20];

    // The held word moves on when the output register is empty or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_result_reg <= step_result;
        end
    end

    // Configuration registers; the port never stalls.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (vtce_pkg::cfg_idx_t'(cfg_index))
                vtce_pkg::REG_PCR:     cfg_reg.pcr      <= cfg_data[7:0];
                vtce_pkg::REG_ACR:     cfg_reg.acr      <= cfg_data[7:0];
                vtce_pkg::REG_IER:     cfg_reg.ier      <= cfg_data[vtce_pkg::FlagWidth-1:0];
                vtce_pkg::REG_T1LATCH: cfg_reg.t1_latch <= cfg_data;
                default:               cfg_reg          <= cfg_reg;
            endcase
        end
    end

    vtce_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_result_reg;

endmodule

// ===== rtl/core/vtce_checker.sv =====
// Port-level checker for the VIA timer and control-edge core, bound to the top level.
module vtce_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed or dropped while stalled");

    // Nothing is shown in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A draining output side never stalls the input side.
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // Flag bit 2 has no source and always reads zero.
    a_flag_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[3] == 1'b0)
        else $error("unused flag bit set");

    // A result appears only after an accepted word.
    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without an accepted word");

endmodule

bind via_timers_and_control_edges vtce_checker u_vtce_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
